// File: hw/rtl/tcba_pkg.sv
package tcba_pkg;

   localparam int PRICE_W = 32;
   localparam int QTY_W   = 32;
   localparam int TIME_W  = 48;
   localparam int STEP_W  = 16;
   localparam int BASE_W  = 32;
   localparam int TF_W    = 22;
   localparam int DELTA_W = 64;
   localparam int VOL_W   = 48;
   localparam int STAMP_W = 32;
   localparam int CSR_W   = 32;
   localparam int CSR_IDX_W = 2;
   localparam int DIV_CNT_W = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_PRICE_STEP  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BUCKET_BASE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEFRAME   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CUM_MODE    = 2'd3;

   localparam logic [TF_W-1:0]      TF_DEFAULT = 22'd1000;
   localparam logic [VOL_W-1:0]     VOL_MAX    = {VOL_W{1'b1}};
   localparam logic [DIV_CNT_W-1:0] PRICE_ITERS = 6'd32;
   localparam logic [DIV_CNT_W-1:0] TIME_ITERS  = 6'd48;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV_PRICE,
      ST_DIV_TIME,
      ST_LOOKUP,
      ST_READ,
      ST_UPDATE,
      ST_CANDLE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [STAMP_W-1:0] stamp;
      logic [VOL_W-1:0]   vol;
   } mem_word_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_CNT_W-1:0] iters;
      logic [TIME_W-1:0]    dividend;
      logic [TF_W-1:0]      divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [TIME_W-1:0] quotient;
      logic [TF_W-1:0]   remainder;
   } div_rsp_type;

endpackage

// File: hw/rtl/tcba_div.sv
module tcba_div (
   input  logic                 clock,
   input  logic                 reset,
   input  tcba_pkg::div_req_type req,
   output tcba_pkg::div_rsp_type rsp
);
   import tcba_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [TIME_W-1:0]    dvd_ff;
   logic [TIME_W-1:0]    quo_ff;
   logic [TF_W-1:0]      rem_ff;
   logic [TF_W-1:0]      dvs_ff;
   logic [TF_W:0]        trial;
   logic                 fits;

   assign trial = {rem_ff, dvd_ff[TIME_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (req.start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= req.iters;
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff - 1'b1;
         busy_ff <= (cnt_ff != 6'd1);
         done_ff <= (cnt_ff == 6'd1);
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         dvd_ff <= req.dividend;
         dvs_ff <= req.divisor;
         quo_ff <= '0;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[TIME_W-2:0], 1'b0};
         quo_ff <= {quo_ff[TIME_W-2:0], fits};
         rem_ff <= fits ? TF_W'(trial - {1'b0, dvs_ff}) : trial[TF_W-1:0];
      end
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

// File: hw/rtl/trade_candle_and_bucket_aggregator_top.sv
// flow: a 32-step division for the bucket, a 48-step division for the candle
// start, then lookup, table read, update, candle update, output register
// one item at a time: none is taken before the last one is emitted; both
// divisions share one shift-subtract divider. reset: synchronous; afterwards
// a table sweep clears both bucket tables, during which no item is taken
module trade_candle_and_bucket_aggregator_top #(
   parameter int PRICE_LEVELS = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [tcba_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tcba_pkg::CSR_W-1:0]      csr_wdata,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [tcba_pkg::PRICE_W-1:0]    req_price,
   input  logic [tcba_pkg::QTY_W-1:0]      req_quantity,
   input  logic [tcba_pkg::TIME_W-1:0]     req_trade_time_ms,
   input  logic                            req_is_sell,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [tcba_pkg::TIME_W-1:0]     rsp_candle_start_ms,
   output logic [tcba_pkg::PRICE_W-1:0]    rsp_open_price,
   output logic [tcba_pkg::PRICE_W-1:0]    rsp_high_price,
   output logic [tcba_pkg::PRICE_W-1:0]    rsp_low_price,
   output logic [tcba_pkg::PRICE_W-1:0]    rsp_close_price,
   output logic signed [tcba_pkg::DELTA_W-1:0] rsp_delta_open,
   output logic signed [tcba_pkg::DELTA_W-1:0] rsp_delta_high,
   output logic signed [tcba_pkg::DELTA_W-1:0] rsp_delta_low,
   output logic signed [tcba_pkg::DELTA_W-1:0] rsp_delta_close,
   output logic [tcba_pkg::VOL_W-1:0]      rsp_bucket_volume,
   output logic [tcba_pkg::VOL_W-1:0]      rsp_max_bucket_volume,
   output logic [tcba_pkg::QTY_W-1:0]      rsp_max_trade_size
);
   import tcba_pkg::*;

   localparam int IDX_W = $clog2(PRICE_LEVELS);

   state_type state_ff, state_in;

   logic [STEP_W-1:0] step_ff;
   logic [BASE_W-1:0] base_ff;
   logic [TF_W-1:0]   tf_ff;
   logic              cum_ff;

   logic [PRICE_W-1:0] price_ff;
   logic [QTY_W-1:0]   qty_ff;
   logic [TIME_W-1:0]  time_ff;
   logic               sell_ff;

   logic [PRICE_W-1:0] bucket_ff;
   logic [TIME_W-1:0]  start_ff;
   logic               in_range_ff;
   logic [IDX_W-1:0]   entry_ff;
   logic [IDX_W-1:0]   clr_cnt_ff;

   logic signed [DELTA_W-1:0] delta_ff;
   logic                      present_ff;
   logic [TIME_W-1:0]         cstart_ff;
   logic [PRICE_W-1:0]        p_open_ff, p_high_ff, p_low_ff, p_close_ff;
   logic signed [DELTA_W-1:0] d_open_ff, d_high_ff, d_low_ff, d_close_ff;
   logic [STAMP_W-1:0]        sell_gen_ff, buy_gen_ff;
   logic [PRICE_W-1:0]        last_sell_ff, last_buy_ff;
   logic [VOL_W-1:0]          peak_bucket_ff;
   logic [QTY_W-1:0]          peak_trade_ff;
   logic [VOL_W-1:0]          bvol_ff;

   mem_word_type sell_mem [PRICE_LEVELS];
   mem_word_type buy_mem  [PRICE_LEVELS];
   mem_word_type sell_rd_ff, buy_rd_ff;
   logic         sell_we, buy_we;
   logic [IDX_W-1:0] wr_addr;
   mem_word_type wr_data;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic              accept;
   logic              emit;
   logic [STEP_W-1:0] step_eff;
   logic [TF_W-1:0]   tf_eff;
   logic [BASE_W-1:0] diff;
   logic              range_ok;
   mem_word_type      own_rd, other_rd;
   logic [STAMP_W-1:0] own_gen;
   logic [VOL_W-1:0]  base_vol;
   logic [VOL_W:0]    vol_sum;
   logic [VOL_W-1:0]  new_vol;
   logic [VOL_W-1:0]  peak_a;
   logic [DELTA_W:0]  dsum;
   logic signed [DELTA_W-1:0] delta_new;
   logic              new_candle;

   tcba_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign step_eff = (step_ff == '0) ? STEP_W'(1) : step_ff;
   assign tf_eff   = (tf_ff == '0) ? TF_DEFAULT : tf_ff;
   assign accept   = (state_ff == ST_IDLE) && req_valid;
   assign emit     = (state_ff == ST_EMIT) && (!rsp_valid || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == IDX_W'(PRICE_LEVELS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_DIV_PRICE;
         end
         ST_DIV_PRICE: begin
            if (div_rsp.done) state_in = ST_DIV_TIME;
         end
         ST_DIV_TIME: begin
            if (div_rsp.done) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: state_in = ST_READ;
         ST_READ:   state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_CANDLE;
         ST_CANDLE: state_in = ST_EMIT;
         ST_EMIT: begin
            if (!rsp_valid || !rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      req_stall         = (state_ff != ST_IDLE);
      div_req.start     = 1'b0;
      div_req.iters     = PRICE_ITERS;
      div_req.dividend  = {req_price, 16'b0};
      div_req.divisor   = {6'b0, step_eff};
      sell_we           = 1'b0;
      buy_we            = 1'b0;
      wr_addr           = entry_ff;
      wr_data           = '{stamp: (cum_ff ? own_rd.stamp : own_gen), vol: new_vol};
      case (state_ff)
         ST_CLEAR: begin
            sell_we = 1'b1;
            buy_we  = 1'b1;
            wr_addr = clr_cnt_ff;
            wr_data = '0;
         end
         ST_IDLE: begin
            div_req.start = req_valid;
         end
         ST_DIV_PRICE: begin
            div_req.start    = div_rsp.done;
            div_req.iters    = TIME_ITERS;
            div_req.dividend = time_ff;
            div_req.divisor  = tf_eff;
         end
         ST_UPDATE: begin
            sell_we = in_range_ff && sell_ff;
            buy_we  = in_range_ff && !sell_ff;
         end
         default: begin
         end
      endcase
   end

   // bucket range and table arithmetic
   assign diff     = bucket_ff - base_ff;
   assign range_ok = (bucket_ff >= base_ff) && (diff < BASE_W'(PRICE_LEVELS));

   assign own_rd   = sell_ff ? sell_rd_ff : buy_rd_ff;
   assign other_rd = sell_ff ? buy_rd_ff : sell_rd_ff;
   assign own_gen  = sell_ff ? sell_gen_ff : buy_gen_ff;
   assign base_vol = (!cum_ff && (own_rd.stamp != own_gen)) ? '0 : own_rd.vol;
   assign vol_sum  = {1'b0, base_vol} + {17'b0, qty_ff};
   assign new_vol  = vol_sum[VOL_W] ? VOL_MAX : vol_sum[VOL_W-1:0];
   assign peak_a   = (new_vol > peak_bucket_ff) ? new_vol : peak_bucket_ff;

   assign dsum = sell_ff ? ({delta_ff[DELTA_W-1], delta_ff} - {33'b0, qty_ff})
                         : ({delta_ff[DELTA_W-1], delta_ff} + {33'b0, qty_ff});
   always_comb begin
      if (dsum[DELTA_W] != dsum[DELTA_W-1]) begin
         delta_new = dsum[DELTA_W] ? {1'b1, {(DELTA_W-1){1'b0}}}
                                   : {1'b0, {(DELTA_W-1){1'b1}}};
      end else begin
         delta_new = dsum[DELTA_W-1:0];
      end
   end

   assign new_candle = !present_ff || (cstart_ff < start_ff);

   always_ff @(posedge clock) begin
      if (sell_we) sell_mem[wr_addr] <= wr_data;
      if (buy_we) buy_mem[wr_addr] <= wr_data;
      sell_rd_ff <= sell_mem[entry_ff];
      buy_rd_ff  <= buy_mem[entry_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_W'(1);
         base_ff <= '0;
         tf_ff   <= TF_DEFAULT;
         cum_ff  <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PRICE_STEP:  step_ff <= csr_wdata[STEP_W-1:0];
            CSR_BUCKET_BASE: base_ff <= csr_wdata[BASE_W-1:0];
            CSR_TIMEFRAME:   tf_ff   <= csr_wdata[TF_W-1:0];
            CSR_CUM_MODE:    cum_ff  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         price_ff <= req_price;
         qty_ff   <= req_quantity;
         time_ff  <= req_trade_time_ms;
         sell_ff  <= req_is_sell;
      end
      if (state_ff == ST_DIV_PRICE && div_rsp.done) bucket_ff <= div_rsp.quotient[PRICE_W-1:0];
      if (state_ff == ST_DIV_TIME && div_rsp.done) begin
         start_ff <= time_ff - {26'b0, div_rsp.remainder};
      end
      if (state_ff == ST_LOOKUP) begin
         in_range_ff <= range_ok;
         entry_ff    <= diff[IDX_W-1:0];
      end
      if (state_ff == ST_UPDATE) bvol_ff <= in_range_ff ? new_vol : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delta_ff       <= '0;
         present_ff     <= 1'b0;
         cstart_ff      <= '0;
         sell_gen_ff    <= '0;
         buy_gen_ff     <= '0;
         last_sell_ff   <= '0;
         last_buy_ff    <= '0;
         peak_bucket_ff <= '0;
         peak_trade_ff  <= '0;
      end else begin
         case (state_ff)
            ST_LOOKUP: begin
               if (!cum_ff) begin
                  if (sell_ff && (bucket_ff != last_sell_ff)) begin
                     sell_gen_ff  <= sell_gen_ff + 1'b1;
                     last_sell_ff <= bucket_ff;
                  end
                  if (!sell_ff && (bucket_ff != last_buy_ff)) begin
                     buy_gen_ff  <= buy_gen_ff + 1'b1;
                     last_buy_ff <= bucket_ff;
                  end
               end
            end
            ST_UPDATE: begin
               if (in_range_ff) begin
                  peak_bucket_ff <= (other_rd.vol > peak_a) ? other_rd.vol : peak_a;
               end
               delta_ff <= delta_new;
               if (qty_ff > peak_trade_ff) peak_trade_ff <= qty_ff;
            end
            ST_CANDLE: begin
               if (new_candle) begin
                  present_ff <= 1'b1;
                  cstart_ff  <= start_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // candle payload
   always_ff @(posedge clock) begin
      if (state_ff == ST_CANDLE) begin
         if (new_candle) begin
            p_open_ff  <= price_ff;
            p_high_ff  <= price_ff;
            p_low_ff   <= price_ff;
            p_close_ff <= price_ff;
            d_open_ff  <= delta_ff;
            d_high_ff  <= delta_ff;
            d_low_ff   <= delta_ff;
            d_close_ff <= delta_ff;
         end else begin
            if (price_ff > p_high_ff) p_high_ff <= price_ff;
            if (price_ff < p_low_ff) p_low_ff <= price_ff;
            p_close_ff <= price_ff;
            if (delta_ff > d_high_ff) d_high_ff <= delta_ff;
            if (delta_ff < d_low_ff) d_low_ff <= delta_ff;
            d_close_ff <= delta_ff;
         end
      end
   end

   // output register
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_candle_start_ms   <= cstart_ff;
         rsp_open_price        <= p_open_ff;
         rsp_high_price        <= p_high_ff;
         rsp_low_price         <= p_low_ff;
         rsp_close_price       <= p_close_ff;
         rsp_delta_open        <= d_open_ff;
         rsp_delta_high        <= d_high_ff;
         rsp_delta_low         <= d_low_ff;
         rsp_delta_close       <= d_close_ff;
         rsp_bucket_volume     <= bvol_ff;
         rsp_max_bucket_volume <= peak_bucket_ff;
         rsp_max_trade_size    <= peak_trade_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: tb/sv/trade_candle_and_bucket_aggregator_top_tb.sv
module trade_candle_and_bucket_aggregator_top_tb;
   import tcba_pkg::*;

   localparam int LEVELS = 1024;
   localparam int IDLE_LIMIT = 20000;

   typedef struct {
      logic [TIME_W-1:0]         start_ms;
      logic [PRICE_W-1:0]        open_p;
      logic [PRICE_W-1:0]        high_p;
      logic [PRICE_W-1:0]        low_p;
      logic [PRICE_W-1:0]        close_p;
      logic signed [DELTA_W-1:0] d_open;
      logic signed [DELTA_W-1:0] d_high;
      logic signed [DELTA_W-1:0] d_low;
      logic signed [DELTA_W-1:0] d_close;
      logic [VOL_W-1:0]          bvol;
      logic [VOL_W-1:0]          peak_vol;
      logic [QTY_W-1:0]          peak_qty;
   } candle_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [PRICE_W-1:0] req_price = '0;
   logic [QTY_W-1:0] req_quantity = '0;
   logic [TIME_W-1:0] req_trade_time_ms = '0;
   logic req_is_sell = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [TIME_W-1:0] rsp_candle_start_ms;
   logic [PRICE_W-1:0] rsp_open_price, rsp_high_price, rsp_low_price, rsp_close_price;
   logic signed [DELTA_W-1:0] rsp_delta_open, rsp_delta_high, rsp_delta_low, rsp_delta_close;
   logic [VOL_W-1:0] rsp_bucket_volume, rsp_max_bucket_volume;
   logic [QTY_W-1:0] rsp_max_trade_size;

   trade_candle_and_bucket_aggregator_top #(.PRICE_LEVELS(LEVELS)) dut (.*);

   initial forever #5 clock = ~clock;

   // predictor state, index 1 is the sell side
   logic [STEP_W-1:0] cfg_step = 1;
   logic [BASE_W-1:0] cfg_base = 0;
   logic [TF_W-1:0] cfg_tf = TF_DEFAULT;
   logic cfg_cum = 0;
   logic signed [DELTA_W-1:0] run_delta;
   logic have_candle;
   candle_type cur;
   logic [VOL_W-1:0] side_vol [2][LEVELS];
   logic [STAMP_W-1:0] side_stamp [2][LEVELS];
   logic [STAMP_W-1:0] side_gen [2];
   logic [31:0] side_last [2];

   candle_type pending_candles[$];
   int errors = 0;
   int n_items = 0;
   int n_results = 0;
   int n_cfg = 0;
   int idle_cycles = 0;
   int burst_left = 0;
   int stall_mode = 0;
   int stall_left = 0;
   logic [TIME_W-1:0] clock_ms = 0;

   function automatic candle_type predict_trade(logic [31:0] price, logic [31:0] qty,
                                                logic [47:0] t, logic sell);
      logic [31:0] step;
      logic [47:0] tf;
      logic [31:0] bucket;
      logic [31:0] entry;
      logic in_range;
      logic [48:0] sum;
      logic [47:0] start;
      logic signed [DELTA_W-1:0] q64;
      int s;
      step = (cfg_step == 0) ? 32'd1 : {16'd0, cfg_step};
      tf = (cfg_tf == 0) ? 48'd1000 : {26'd0, cfg_tf};
      bucket = price / step;
      entry = bucket - cfg_base;
      in_range = (bucket >= cfg_base) && (entry < LEVELS);
      s = sell ? 1 : 0;
      cur.bvol = 0;
      if (!cfg_cum) begin
         if (bucket != side_last[s]) begin
            side_gen[s] = side_gen[s] + 1;
            side_last[s] = bucket;
         end
         if (in_range && side_stamp[s][entry] != side_gen[s]) begin
            side_vol[s][entry] = 0;
            side_stamp[s][entry] = side_gen[s];
         end
      end
      if (in_range) begin
         sum = {1'b0, side_vol[s][entry]} + qty;
         if (sum > {1'b0, VOL_MAX}) sum = {1'b0, VOL_MAX};
         side_vol[s][entry] = sum[47:0];
         cur.bvol = sum[47:0];
         if (side_vol[1][entry] > cur.peak_vol) cur.peak_vol = side_vol[1][entry];
         if (side_vol[0][entry] > cur.peak_vol) cur.peak_vol = side_vol[0][entry];
      end
      q64 = {32'd0, qty};
      if (sell) begin
         if (run_delta < 64'sh8000000000000000 + q64) run_delta = 64'sh8000000000000000;
         else run_delta = run_delta - q64;
      end else begin
         if (run_delta > 64'sh7fffffffffffffff - q64) run_delta = 64'sh7fffffffffffffff;
         else run_delta = run_delta + q64;
      end
      if (qty > cur.peak_qty) cur.peak_qty = qty;
      start = (t / tf) * tf;
      if (!have_candle || cur.start_ms < start) begin
         have_candle = 1;
         cur.start_ms = start;
         cur.open_p = price; cur.high_p = price; cur.low_p = price; cur.close_p = price;
         cur.d_open = run_delta; cur.d_high = run_delta;
         cur.d_low = run_delta; cur.d_close = run_delta;
      end else begin
         if (price > cur.high_p) cur.high_p = price;
         if (price < cur.low_p) cur.low_p = price;
         cur.close_p = price;
         if (run_delta > cur.d_high) cur.d_high = run_delta;
         if (run_delta < cur.d_low) cur.d_low = run_delta;
         cur.d_close = run_delta;
      end
      return cur;
   endfunction

   task automatic send_trade(logic [31:0] price, logic [31:0] qty, logic [47:0] t,
                             logic sell);
      int gap;
      candle_type predicted;
      req_valid <= 1'b1;
      req_price <= price;
      req_quantity <= qty;
      req_trade_time_ms <= t;
      req_is_sell <= sell;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      predicted = predict_trade(price, qty, t, sell);
      pending_candles.insert(pending_candles.size(), predicted);
      n_items++;
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending_candles.size() != 0) @(negedge clock);
      repeat (120) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      n_cfg++;
   endtask

   task automatic apply_config(logic [15:0] step, logic [31:0] base, logic [21:0] tf,
                               logic cum);
      drain();
      write_csr(CSR_PRICE_STEP, {16'd0, step});
      write_csr(CSR_BUCKET_BASE, base);
      write_csr(CSR_TIMEFRAME, {10'd0, tf});
      write_csr(CSR_CUM_MODE, {31'd0, cum});
      csr_wr_en <= 1'b0;
      cfg_step = step; cfg_base = base; cfg_tf = tf; cfg_cum = cum;
   endtask

   task automatic random_trades(int count);
      logic [31:0] price, qty, bucket, step;
      logic [47:0] t, tf;
      int r;
      step = (cfg_step == 0) ? 1 : cfg_step;
      tf = (cfg_tf == 0) ? 1000 : cfg_tf;
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < 75) bucket = cfg_base + (($urandom_range(0, 3) == 0) ?
                                          $urandom_range(0, LEVELS - 1) : $urandom_range(0, 5));
         else if (r < 85) bucket = $urandom;
         else bucket = $urandom_range(0, 1) ? cfg_base - 1 : cfg_base + LEVELS;
         price = bucket * step + $urandom_range(0, step - 1);
         if (r >= 75 && r < 85) price = $urandom;
         r = $urandom_range(0, 99);
         if (r < 70) qty = $urandom_range(0, 1000);
         else if (r < 90) qty = $urandom;
         else qty = $urandom_range(0, 1) ? 32'hffffffff : 32'd0;
         r = $urandom_range(0, 99);
         if (r < 80) begin
            clock_ms = clock_ms + $urandom_range(0, tf / 2 + 1);
            t = clock_ms;
         end else if (r < 92) begin
            t = (clock_ms > 2 * tf) ? clock_ms - $urandom_range(0, 2 * tf) : 0;
         end else if (r < 97) begin
            clock_ms = TIME_W'({$urandom, $urandom});
            t = clock_ms;
         end else begin
            t = $urandom_range(0, 1) ? 48'hffffffffffff : 48'd0;
         end
         send_trade(price, qty, t, $urandom_range(0, 1));
      end
   endtask

   task automatic test_directed_default;
      send_trade(32'd0, 32'd0, 48'd0, 1'b0);
      send_trade(32'd0, 32'hffffffff, 48'd10, 1'b0);
      send_trade(32'd0, 32'd5, 48'd20, 1'b1);
      send_trade(32'd1, 32'd7, 48'd30, 1'b1);
      send_trade(32'd0, 32'd9, 48'd40, 1'b1);
      send_trade(32'd1023, 32'd3, 48'd999, 1'b0);
      send_trade(32'd1024, 32'd3, 48'd1000, 1'b0);
      send_trade(32'hffffffff, 32'hffffffff, 48'd1500, 1'b1);
      send_trade(32'd500, 32'd1, 48'd200, 1'b0);
      send_trade(32'd500, 32'd2, 48'hffffffffffff, 1'b1);
      send_trade(32'd600, 32'd4, 48'd5, 1'b0);
      send_trade(32'd600, 32'd4, 48'hfffffffffff0, 1'b0);
   endtask

   task automatic test_directed_base;
      apply_config(16'd10, 32'd100, 22'd1, 1'b0);
      send_trade(32'd999, 32'd6, 48'd0, 1'b0);
      send_trade(32'd1000, 32'd6, 48'd1, 1'b0);
      send_trade(32'd11239, 32'd6, 48'd2, 1'b1);
      send_trade(32'd11240, 32'd6, 48'd3, 1'b1);
      apply_config(16'd0, 32'hffffffff, 22'd0, 1'b1);
      send_trade(32'hffffffff, 32'd8, 48'd0, 1'b0);
      send_trade(32'hfffffffe, 32'd8, 48'd999, 1'b1);
      send_trade(32'hffffffff, 32'd8, 48'd1000, 1'b0);
   endtask

   task automatic test_random_default;
      apply_config(16'd1, 32'd0, 22'd1000, 1'b0);
      random_trades(300);
   endtask

   task automatic test_random_cumulative;
      apply_config(16'd3, 32'd50, 22'd250, 1'b1);
      random_trades(250);
   endtask

   task automatic test_random_extremes;
      apply_config(16'hffff, 32'd0, 22'd3600000, 1'b0);
      random_trades(200);
      apply_config(16'd0, 32'd0, 22'd0, 1'b0);
      random_trades(150);
      apply_config(16'h8001, 32'h0001fffc, 22'h3fffff, 1'b1);
      random_trades(150);
   endtask

   task automatic test_random_config;
      repeat (4) begin
         apply_config($urandom, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 64),
                      $urandom_range(0, 3600000), $urandom_range(0, 1));
         random_trades(50);
      end
   endtask

   task automatic report_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      candle_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_results++;
         if (pending_candles.size() == 0) begin
            errors++;
            $display("%0t: unexpected item, expected none, actual start %h", $time,
                     rsp_candle_start_ms);
         end else begin
            e = pending_candles.pop_front();
            report_field("candle_start_ms", e.start_ms, rsp_candle_start_ms);
            report_field("open_price", e.open_p, rsp_open_price);
            report_field("high_price", e.high_p, rsp_high_price);
            report_field("low_price", e.low_p, rsp_low_price);
            report_field("close_price", e.close_p, rsp_close_price);
            report_field("delta_open", e.d_open, rsp_delta_open);
            report_field("delta_high", e.d_high, rsp_delta_high);
            report_field("delta_low", e.d_low, rsp_delta_low);
            report_field("delta_close", e.d_close, rsp_delta_close);
            report_field("bucket_volume", e.bvol, rsp_bucket_volume);
            report_field("max_bucket_volume", e.peak_vol, rsp_max_bucket_volume);
            report_field("max_trade_size", e.peak_qty, rsp_max_trade_size);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout with %0d items outstanding", pending_candles.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(50, 600);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 2) == 0);
         2: rsp_stall <= ($urandom_range(0, 9) != 0);
         default: rsp_stall <= (stall_left % 40) < 15;
      endcase
   end

   initial begin
      int i;
      for (i = 0; i < LEVELS; i++) begin
         side_vol[0][i] = 0; side_vol[1][i] = 0;
         side_stamp[0][i] = 0; side_stamp[1][i] = 0;
      end
      side_gen[0] = 0; side_gen[1] = 0;
      side_last[0] = 0; side_last[1] = 0;
      run_delta = 0;
      have_candle = 0;
      cur = '{default: 0};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_default();
      test_directed_base();
      test_random_default();
      test_random_cumulative();
      test_random_extremes();
      test_random_config();
      drain();
      repeat (100) @(negedge clock);
      $display("covered %0d trades, %0d results, %0d register writes", n_items, n_results,
               n_cfg);
      $display("default and cumulative bucket modes, step, base and timeframe extremes");
      if (errors == 0 && pending_candles.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
